@@ rtl/tse_pkg.sv @@
package tse_pkg;

	localparam logic [5:0] MAX_TERMS = 6'd32;

	localparam logic [2:0] CMD_EXP = 3'd0;
	localparam logic [2:0] CMD_LN  = 3'd1;
	localparam logic [2:0] CMD_SIN = 3'd2;
	localparam logic [2:0] CMD_COS = 3'd3;
	localparam logic [2:0] CMD_REC = 3'd4;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_SAT    = 2'd1;
	localparam logic [1:0] STAT_DOMAIN = 2'd2;

	localparam logic [31:0] ONE_Q28 = 32'h1000_0000;
	localparam logic [47:0] ONE_Q32 = 48'h0001_0000_0000;
	localparam logic [47:0] MAX48   = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] MIN48   = 48'h8000_0000_0000;

	localparam logic [5:0] MUL_SHORT = 6'd32;
	localparam logic [5:0] MUL_LONG  = 6'd63;
	localparam logic [5:0] DIV_STEPS = 6'd27;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] arg_x;
		logic [5:0]         term_count;
	} request_t;

	typedef struct packed {
		logic signed [47:0] term_value;
		logic signed [47:0] running_sum;
		logic               is_total;
		logic [1:0]         status;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_SQD,
		S_PREP,
		S_RND,
		S_DIV,
		S_RECM,
		S_POST,
		S_FINAL
	} state_t;

endpackage

@@ rtl/taylor_series_evaluator.sv @@
// Taylor-series evaluator for e^x, ln(1+x), sin x, cos x and 1/(1-x)^2 with x in signed Q4.28.
// A request is taken at a clock edge where start is high and busy is low; busy then stays high
// until the last result has been issued. Every series term gives one result (term and running
// sum in saturated Q16.32), followed by one result flagged is_total that carries the total.
// Results appear on result for a single cycle, marked by result_valid, and cannot be held off,
// so the receiver must take every strobe. A request with an unknown function, an ln or
// 1/(1-x)^2 request with |x| > 1.0, or a term count of zero yields only the total result, in the
// cycle after the request, and busy never rises. The series products run through one bit-serial
// shift-add multiplier (one multiplier bit per cycle) and, for all but 1/(1-x)^2, one restoring
// divider that retires two quotient bits per cycle; 1/(1-x)^2 instead scales its power of x by
// i+1 with a separate multiplier. sin x and cos x first square x on the shift-add multiplier.
// Term counts above 32 are clamped to 32.
module taylor_series_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tse_pkg::request_t  request,
	output logic               busy,
	output logic               result_valid,
	output tse_pkg::result_t   result
);

	tse_pkg::state_t state_q, state_d;

	logic [2:0]         cmd_q;
	logic               x_neg_q;
	logic [31:0]        x_mag_q;
	logic [5:0]         n_q;
	logic [5:0]         i_q;
	logic signed [47:0] ct_q;
	logic signed [47:0] acc_q;
	logic               p_neg_q;
	logic [32:0]        p_mag_q;
	logic [62:0]        x2_q;
	logic [47:0]        mc_q;
	logic [48:0]        hi_q;
	logic [62:0]        lo_q;
	logic [5:0]         cnt_q;
	logic [13:0]        d_q;
	logic [53:0]        quo_q;
	logic [13:0]        rem_q;
	logic               neg_q;
	logic               sat_q;
	logic               sq_q;
	logic               valid_q;
	tse_pkg::result_t   res_q;

	logic        accept;
	logic [31:0] arg_raw;
	logic [31:0] x_mag_in;
	logic        bad_in;
	logic [5:0]  n_in;
	logic [47:0] ct_init;
	logic        trig;
	logic [47:0] ct_mag;
	logic [6:0]  two_i;
	logic [6:0]  two_i_p1;
	logic [6:0]  two_i_m1;
	logic [13:0] d_sin;
	logic [13:0] d_cos;
	logic [48:0] madd;
	logic [52:0] r28;
	logic [55:0] r56;
	logic [53:0] rnd_mag;
	logic [53:0] dividend;
	logic [14:0] dv_r1;
	logic        dv_ge1;
	logic [13:0] dv_m1;
	logic [14:0] dv_r2;
	logic        dv_ge2;
	logic [13:0] dv_m2;
	logic [6:0]  i_p1;
	logic [39:0] rec_prod;
	logic        term_sat;
	logic [47:0] term_d;
	logic [48:0] sum49;
	logic        sum_sat;
	logic [47:0] sum_d;
	logic        emit;

	// request decode
	assign accept   = start && (state_q == tse_pkg::S_IDLE);
	assign arg_raw  = request.arg_x;
	assign x_mag_in = arg_raw[31] ? (~arg_raw + 32'd1) : arg_raw;
	assign bad_in   = (request.command > tse_pkg::CMD_REC)
		|| (((request.command == tse_pkg::CMD_LN) || (request.command == tse_pkg::CMD_REC))
		&& (x_mag_in > tse_pkg::ONE_Q28));
	assign n_in     = (request.term_count > tse_pkg::MAX_TERMS) ? tse_pkg::MAX_TERMS
		: request.term_count;

	always_comb begin
		case (request.command)
			tse_pkg::CMD_LN:  ct_init = 48'd0;
			tse_pkg::CMD_SIN: ct_init = {{12{arg_raw[31]}}, arg_raw, 4'd0};
			default:          ct_init = tse_pkg::ONE_Q32;
		endcase
	end

	// step setup
	assign trig     = (cmd_q == tse_pkg::CMD_SIN) || (cmd_q == tse_pkg::CMD_COS);
	assign ct_mag   = ct_q[47] ? (~ct_q + 48'd1) : ct_q;
	assign two_i    = {i_q, 1'b0};
	assign two_i_p1 = {i_q, 1'b1};
	assign two_i_m1 = {i_q - 6'd1, 1'b1};
	assign d_sin    = {7'd0, two_i} * {7'd0, two_i_p1};
	assign d_cos    = {7'd0, two_i_m1} * {7'd0, two_i};

	// shift-add multiplier step
	assign madd = hi_q + (lo_q[0] ? {1'b0, mc_q} : 49'd0);

	// rounding of the product, half away from zero on the magnitude
	assign r28      = {hi_q, lo_q[62:59]} + {52'd0, lo_q[58]};
	assign r56      = {hi_q, lo_q[62:56]} + {55'd0, lo_q[55]};
	assign rnd_mag  = trig ? r56[53:0] : {1'b0, r28};
	assign dividend = rnd_mag + {41'd0, d_q[13:1]};

	// restoring divider, two quotient bits per cycle
	assign dv_r1  = {rem_q, quo_q[53]};
	assign dv_ge1 = dv_r1 >= {1'b0, d_q};
	assign dv_m1  = dv_ge1 ? 14'(dv_r1 - {1'b0, d_q}) : dv_r1[13:0];
	assign dv_r2  = {dv_m1, quo_q[52]};
	assign dv_ge2 = dv_r2 >= {1'b0, d_q};
	assign dv_m2  = dv_ge2 ? 14'(dv_r2 - {1'b0, d_q}) : dv_r2[13:0];

	assign i_p1     = {1'b0, i_q} + 7'd1;
	assign rec_prod = {7'd0, p_mag_q} * {33'd0, i_p1};

	// term and sum saturation
	always_comb begin
		if (neg_q) begin
			term_sat = (|quo_q[53:48]) || (quo_q[47] && (|quo_q[46:0]));
		end else begin
			term_sat = |quo_q[53:47];
		end
		if (term_sat) begin
			term_d = neg_q ? tse_pkg::MIN48 : tse_pkg::MAX48;
		end else begin
			term_d = neg_q ? (~quo_q[47:0] + 48'd1) : quo_q[47:0];
		end
		sum49   = {acc_q[47], acc_q} + {term_d[47], term_d};
		sum_sat = sum49[48] ^ sum49[47];
		if (sum_sat) begin
			sum_d = sum49[48] ? tse_pkg::MIN48 : tse_pkg::MAX48;
		end else begin
			sum_d = sum49[47:0];
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		unique case (state_q)
			tse_pkg::S_IDLE: begin
				if (accept) begin
					if (bad_in || (n_in == 6'd0)) begin
						emit = 1'b1;
					end else if ((request.command == tse_pkg::CMD_SIN)
						|| (request.command == tse_pkg::CMD_COS)) begin
						state_d = tse_pkg::S_MUL;
					end else begin
						state_d = tse_pkg::S_PREP;
					end
				end
			end
			tse_pkg::S_MUL: begin
				if (cnt_q == 6'd1) begin
					state_d = sq_q ? tse_pkg::S_SQD : tse_pkg::S_RND;
				end
			end
			tse_pkg::S_SQD:  state_d = tse_pkg::S_PREP;
			tse_pkg::S_PREP: state_d = tse_pkg::S_MUL;
			tse_pkg::S_RND: begin
				state_d = (cmd_q == tse_pkg::CMD_REC) ? tse_pkg::S_RECM : tse_pkg::S_DIV;
			end
			tse_pkg::S_DIV: begin
				if (cnt_q == 6'd1) begin
					state_d = tse_pkg::S_POST;
				end
			end
			tse_pkg::S_RECM: state_d = tse_pkg::S_POST;
			tse_pkg::S_POST: begin
				emit    = 1'b1;
				state_d = (i_q == n_q) ? tse_pkg::S_FINAL : tse_pkg::S_PREP;
			end
			tse_pkg::S_FINAL: begin
				emit    = 1'b1;
				state_d = tse_pkg::S_IDLE;
			end
			default: state_d = tse_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tse_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sat_q   <= 1'b0;
			sq_q    <= 1'b0;
		end else begin
			valid_q <= emit;
			if (accept) begin
				sat_q <= 1'b0;
				sq_q  <= (request.command == tse_pkg::CMD_SIN)
					|| (request.command == tse_pkg::CMD_COS);
			end else if (state_q == tse_pkg::S_PREP) begin
				sq_q <= 1'b0;
			end else if (state_q == tse_pkg::S_POST) begin
				sat_q <= sat_q || term_sat || sum_sat;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			tse_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q   <= request.command;
					x_neg_q <= arg_raw[31];
					x_mag_q <= x_mag_in;
					n_q     <= n_in;
					i_q     <= 6'd1;
					p_neg_q <= 1'b0;
					p_mag_q <= {1'b1, 32'd0};
					ct_q    <= ct_init;
					acc_q   <= ct_init;
					// x squared for the trig series
					mc_q    <= {16'd0, x_mag_in};
					hi_q    <= 49'd0;
					lo_q    <= {31'd0, x_mag_in};
					cnt_q   <= tse_pkg::MUL_SHORT;
					if (bad_in) begin
						res_q.term_value  <= 48'd0;
						res_q.running_sum <= 48'd0;
						res_q.is_total    <= 1'b1;
						res_q.status      <= tse_pkg::STAT_DOMAIN;
					end else begin
						res_q.term_value  <= ct_init;
						res_q.running_sum <= ct_init;
						res_q.is_total    <= 1'b1;
						res_q.status      <= tse_pkg::STAT_OK;
					end
				end
			end
			tse_pkg::S_MUL: begin
				hi_q  <= {1'b0, madd[48:1]};
				lo_q  <= {madd[0], lo_q[62:1]};
				cnt_q <= cnt_q - 6'd1;
			end
			tse_pkg::S_SQD: begin
				x2_q <= {hi_q[30:0], lo_q[62:31]};
			end
			tse_pkg::S_PREP: begin
				hi_q <= 49'd0;
				case (cmd_q)
					tse_pkg::CMD_SIN: d_q <= d_sin;
					tse_pkg::CMD_COS: d_q <= d_cos;
					default:          d_q <= {8'd0, i_q};
				endcase
				if (trig) begin
					mc_q  <= ct_mag;
					lo_q  <= x2_q;
					cnt_q <= tse_pkg::MUL_LONG;
				end else begin
					mc_q  <= ((cmd_q == tse_pkg::CMD_EXP) ? ct_mag : {15'd0, p_mag_q});
					lo_q  <= {31'd0, x_mag_q};
					cnt_q <= tse_pkg::MUL_SHORT;
				end
			end
			tse_pkg::S_RND: begin
				rem_q <= 14'd0;
				cnt_q <= tse_pkg::DIV_STEPS;
				quo_q <= dividend;
				case (cmd_q)
					tse_pkg::CMD_EXP: neg_q <= ct_q[47] ^ x_neg_q;
					tse_pkg::CMD_LN: begin
						p_mag_q <= rnd_mag[32:0];
						p_neg_q <= p_neg_q ^ x_neg_q;
						neg_q   <= p_neg_q ^ x_neg_q ^ ~i_q[0];
					end
					tse_pkg::CMD_REC: begin
						p_mag_q <= rnd_mag[32:0];
						p_neg_q <= p_neg_q ^ x_neg_q;
						neg_q   <= p_neg_q ^ x_neg_q;
					end
					default: neg_q <= ~ct_q[47];
				endcase
			end
			tse_pkg::S_DIV: begin
				quo_q <= {quo_q[51:0], dv_ge1, dv_ge2};
				rem_q <= dv_m2;
				cnt_q <= cnt_q - 6'd1;
			end
			tse_pkg::S_RECM: begin
				quo_q <= {14'd0, rec_prod};
			end
			tse_pkg::S_POST: begin
				ct_q              <= term_d;
				acc_q             <= sum_d;
				i_q               <= i_q + 6'd1;
				res_q.term_value  <= term_d;
				res_q.running_sum <= sum_d;
				res_q.is_total    <= 1'b0;
				res_q.status      <= (sat_q || term_sat || sum_sat) ? tse_pkg::STAT_SAT
					: tse_pkg::STAT_OK;
			end
			tse_pkg::S_FINAL: begin
				res_q.term_value  <= ct_q;
				res_q.running_sum <= acc_q;
				res_q.is_total    <= 1'b1;
				res_q.status      <= sat_q ? tse_pkg::STAT_SAT : tse_pkg::STAT_OK;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign busy         = (state_q != tse_pkg::S_IDLE);
	assign result_valid = valid_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	a_domain_is_total: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == tse_pkg::STAT_DOMAIN) |-> result.is_total)
		else $error("domain error result without total flag");

	a_no_term_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !(result_valid && !result.is_total))
		else $error("term result one cycle after request");

	a_term_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_total |-> busy)
		else $error("term result issued with sequencer idle");

	a_busy_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tse_pkg::*;

	localparam int     RANDOM_REQUESTS = 350;
	localparam int     QUIET_LIMIT     = 20000;
	localparam int     DRAIN_CYCLES    = 40;
	localparam logic [2:0] CMD_RSVD_LO = CMD_REC + 3'd1;
	localparam logic [2:0] CMD_RSVD_HI = 3'd7;
	localparam logic signed [31:0] ARG_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] ARG_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] ARG_ONE  = ONE_Q28;
	localparam logic signed [31:0] ARG_HALF = 32'sh0800_0000;
	localparam longint unsigned MAG_CAP = 64'd1 << 62;
	localparam longint SAT_HI = longint'($signed(MAX48));
	localparam longint SAT_LO = longint'($signed(MIN48));

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     result_valid;
	result_t  result;

	request_t pending_requests[$];
	result_t  expected_results[$];
	result_t  oldest;
	int       total_requests = 0;
	int       sent_count = 0;
	int       failures = 0;
	int       quiet_cycles = 0;

	// series state of the predictor
	longint series_term;
	longint series_sum;
	longint x_power;

	taylor_series_evaluator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned magnitude(longint v);
		longint unsigned u;
		u = v;
		if (v < 0)
			u = -u;
		return u;
	endfunction

	function automatic longint signed_of(bit neg, longint unsigned m);
		longint r;
		if (m > MAG_CAP)
			m = MAG_CAP;
		r = m;
		return neg ? -r : r;
	endfunction

	// product rounded half away from zero at the given shift, magnitude capped at 2^62
	function automatic longint round_mul(longint a, longint b, int shift);
		logic [127:0] prod;
		prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		prod = (prod + (128'd1 << (shift - 1))) >> shift;
		if (prod >= (128'd1 << 62))
			return signed_of((a < 0) != (b < 0), MAG_CAP);
		return signed_of((a < 0) != (b < 0), prod[63:0]);
	endfunction

	function automatic longint round_div(longint a, longint unsigned d);
		longint unsigned m;
		m = magnitude(a);
		return signed_of(a < 0, (m + d / 2) / d);
	endfunction

	function automatic longint clamp48(longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	task automatic evaluate_series(input request_t req);
		int unsigned count;
		longint      arg;
		longint      arg_sq;
		longint      unit_arg;
		longint      raw;
		longint      next_sum;
		bit          clipped;
		result_t     r;
		count = (req.term_count > MAX_TERMS) ? MAX_TERMS : req.term_count;
		arg = $signed(req.arg_x);
		unit_arg = ONE_Q28;
		x_power = ONE_Q32;
		clipped = 1'b0;
		if (req.command > CMD_REC || ((req.command == CMD_LN || req.command == CMD_REC) &&
				(arg > unit_arg || arg < -unit_arg))) begin
			series_term = 0;
			series_sum = 0;
			r.term_value = '0;
			r.running_sum = '0;
			r.is_total = 1'b1;
			r.status = STAT_DOMAIN;
			expected_results.push_back(r);
		end else begin
			arg_sq = magnitude(arg) * magnitude(arg);
			case (req.command)
				CMD_LN: begin
					series_term = 0;
					series_sum = 0;
				end
				CMD_SIN: begin
					series_term = arg * 16;
					series_sum = arg * 16;
				end
				default: begin
					series_term = ONE_Q32;
					series_sum = ONE_Q32;
				end
			endcase
			for (int unsigned step = 1; step <= count; step++) begin
				case (req.command)
					CMD_EXP: raw = round_div(round_mul(series_term, arg, 28), step);
					CMD_LN: begin
						x_power = round_mul(x_power, arg, 28);
						raw = round_div(x_power, step);
						if (step % 2 == 0)
							raw = -raw;
					end
					CMD_SIN: raw = -round_div(round_mul(series_term, arg_sq, 56),
						longint'(2 * step) * (2 * step + 1));
					CMD_COS: raw = -round_div(round_mul(series_term, arg_sq, 56),
						longint'(2 * step - 1) * (2 * step));
					default: begin
						x_power = round_mul(x_power, arg, 28);
						raw = x_power * longint'(step + 1);
					end
				endcase
				series_term = clamp48(raw);
				if (series_term != raw)
					clipped = 1'b1;
				next_sum = series_sum + series_term;
				series_sum = clamp48(next_sum);
				if (series_sum != next_sum)
					clipped = 1'b1;
				r.term_value = series_term[47:0];
				r.running_sum = series_sum[47:0];
				r.is_total = 1'b0;
				r.status = clipped ? STAT_SAT : STAT_OK;
				expected_results.push_back(r);
			end
			r.term_value = series_term[47:0];
			r.running_sum = series_sum[47:0];
			r.is_total = 1'b1;
			r.status = clipped ? STAT_SAT : STAT_OK;
			expected_results.push_back(r);
		end
	endtask

	function automatic request_t make_request(logic [2:0] cmd, logic signed [31:0] arg,
			logic [5:0] terms);
		request_t req;
		req.command = cmd;
		req.arg_x = arg;
		req.term_count = terms;
		return req;
	endfunction

	task automatic flag_mismatch(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		failures++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				evaluate_series(request);
				sent_count++;
			end
			if (!start || !busy) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >=
						(sent_count < total_requests / 3 ? 25 :
						sent_count < 2 * total_requests / 3 ? 70 : 0)) begin
					request <= pending_requests.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					failures++;
					$error("unexpected result: term_value %0d, running_sum %0d",
						result.term_value, result.running_sum);
				end else begin
					oldest = expected_results.pop_front();
					if (result.term_value !== oldest.term_value)
						flag_mismatch("term_value", oldest.term_value, result.term_value);
					if (result.running_sum !== oldest.running_sum)
						flag_mismatch("running_sum", oldest.running_sum, result.running_sum);
					if (result.is_total !== oldest.is_total)
						flag_mismatch("is_total", oldest.is_total, result.is_total);
					if (result.status !== oldest.status)
						flag_mismatch("status", oldest.status, result.status);
				end
			end
			if (result_valid || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** taylor_series_evaluator: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0]         cmd;
		logic signed [31:0] arg;
		logic [5:0]         terms;
		int                 pick;
		int                 full_pct;

		// extremes, domain edges, reserved codes, zero and clamped counts
		pending_requests.push_back(make_request(CMD_EXP, 32'sd0, 6'd0));
		pending_requests.push_back(make_request(CMD_EXP, ARG_ONE, 6'd32));
		pending_requests.push_back(make_request(CMD_EXP, ARG_MAX, 6'd32));
		pending_requests.push_back(make_request(CMD_EXP, ARG_MIN, 6'd63));
		pending_requests.push_back(make_request(CMD_LN, ARG_ONE, 6'd32));
		pending_requests.push_back(make_request(CMD_LN, -ARG_ONE, 6'd32));
		pending_requests.push_back(make_request(CMD_LN, ARG_ONE + 1, 6'd5));
		pending_requests.push_back(make_request(CMD_LN, -ARG_ONE - 1, 6'd5));
		pending_requests.push_back(make_request(CMD_LN, ARG_HALF, 6'd0));
		pending_requests.push_back(make_request(CMD_LN, ARG_MIN, 6'd33));
		pending_requests.push_back(make_request(CMD_SIN, ARG_MAX, 6'd32));
		pending_requests.push_back(make_request(CMD_SIN, ARG_MIN, 6'd40));
		pending_requests.push_back(make_request(CMD_SIN, 32'sd0, 6'd3));
		pending_requests.push_back(make_request(CMD_SIN, $urandom, 6'd0));
		pending_requests.push_back(make_request(CMD_COS, ARG_MAX, 6'd32));
		pending_requests.push_back(make_request(CMD_COS, -(ARG_ONE + ARG_HALF), 6'd10));
		pending_requests.push_back(make_request(CMD_COS, 32'sd0, 6'd0));
		pending_requests.push_back(make_request(CMD_REC, ARG_ONE, 6'd32));
		pending_requests.push_back(make_request(CMD_REC, -ARG_ONE, 6'd32));
		pending_requests.push_back(make_request(CMD_REC, ARG_ONE + 1, 6'd4));
		pending_requests.push_back(make_request(CMD_REC, ARG_MAX, 6'd0));
		pending_requests.push_back(make_request(CMD_REC, 32'sh0C00_0000, 6'd6));
		pending_requests.push_back(make_request(CMD_RSVD_LO, $urandom, 6'd7));
		pending_requests.push_back(make_request(CMD_RSVD_LO + 3'd1, -32'sd1, 6'd0));
		pending_requests.push_back(make_request(CMD_RSVD_HI, ARG_MAX, 6'd63));

		for (int k = 0; k < RANDOM_REQUESTS; k++) begin
			if ($urandom_range(99) < 5)
				cmd = $urandom_range(CMD_RSVD_HI, CMD_RSVD_LO);
			else
				cmd = $urandom_range(CMD_REC);
			// ln and 1/(1-x)^2 mostly stay inside their domain
			full_pct = (cmd == CMD_LN || cmd == CMD_REC) ? 10 : 30;
			pick = $urandom_range(99);
			if (pick < full_pct) begin
				arg = $urandom;
			end else if (pick < 75) begin
				arg = $urandom_range(32'h2000_0000) - 32'h1000_0000;
			end else if (pick < 90) begin
				arg = $urandom_range(32'h0020_0000) - 32'h0010_0000;
			end else begin
				case ($urandom_range(7))
					0: arg = 32'sd0;
					1: arg = ARG_ONE;
					2: arg = -ARG_ONE;
					3: arg = ARG_ONE + 1;
					4: arg = -ARG_ONE - 1;
					5: arg = ARG_MAX;
					6: arg = ARG_MIN;
					default: arg = -32'sd1;
				endcase
			end
			// short series mostly, long and clamped ones now and then
			pick = $urandom_range(99);
			if (pick < 70)
				terms = $urandom_range(6);
			else if (pick < 90)
				terms = $urandom_range(16, 7);
			else
				terms = $urandom_range(63, 17);
			pending_requests.push_back(make_request(cmd, arg, terms));
		end
		total_requests = pending_requests.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("** taylor_series_evaluator: PASSED **");
		else
			$display("** taylor_series_evaluator: FAILED **");
		$finish;
	end

endmodule

@@ taylor_series_evaluator.f @@
rtl/tse_pkg.sv
rtl/taylor_series_evaluator.sv
tb/testbench.sv
